FILE: hw/rtl/tcp_connection_handshake_table_top_macros.svh
// ----------------------------------------------------------------------------
// TCP connection handshake table - assertion macros
// Shared concurrent assertion forms for the table RTL.
// ----------------------------------------------------------------------------
`ifndef TCP_CONNECTION_HANDSHAKE_TABLE_TOP_MACROS_SVH
`define TCP_CONNECTION_HANDSHAKE_TABLE_TOP_MACROS_SVH

// Same-cycle implication.
`define TCHT_ASSERT_IMP(lbl, clk, rst, ant, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
      else $error("tcht assertion failed");

// Next-cycle implication.
`define TCHT_ASSERT_NXT(lbl, clk, rst, ant, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
      else $error("tcht assertion failed");

`endif

FILE: hw/rtl/tcht_pkg.sv
// ----------------------------------------------------------------------------
// TCP connection handshake table - package
// Transfer types, phase codes, register map and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcht_pkg;

   localparam int SLOT_W   = 4;
   localparam int WIN_W    = 17;
   localparam int TUPLE_W  = 96;
   localparam int CSR_AW   = 3;

   localparam logic        MODE_SYN = 1'b0;
   localparam logic        MODE_ACK = 1'b1;

   // Register select is paddr[2]
   localparam logic        CSR_SEL_ISS = 1'b0;
   localparam logic        CSR_SEL_WIN = 1'b1;

   localparam logic [31:0]      ISS_RESET    = 32'h1234_5678;
   localparam logic [WIN_W-1:0] WINDOW_RESET = 17'd65536;

   typedef enum logic [1:0] {
      PHASE_NONE        = 2'd0,
      PHASE_SYN_RCVD    = 2'd1,
      PHASE_ESTABLISHED = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      BE_IDLE,
      BE_SCAN,
      BE_WRITE
   } be_state_type;

   typedef struct packed {
      logic        mode;
      logic [31:0] our_address;
      logic [31:0] peer_address;
      logic [15:0] our_port;
      logic [15:0] peer_port;
      logic [31:0] peer_sequence;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic              created;
      logic              table_full;
      logic [SLOT_W-1:0] slot;
      phase_type         phase_after;
      logic [31:0]       ack_expected;
      logic [31:0]       send_sequence_out;
      logic [WIN_W-1:0]  send_window_out;
   } rsp_type;

   // Head of the segment queue as seen by the back end
   typedef struct packed {
      logic    valid;
      req_type item;
   } queue_head_type;

   typedef struct packed {
      logic [31:0]      iss;
      logic [WIN_W-1:0] window;
   } cfg_type;

   function automatic logic [TUPLE_W-1:0] tuple_of(input req_type r);
      tuple_of = {r.our_address, r.peer_address, r.our_port, r.peer_port};
   endfunction

endpackage

FILE: hw/rtl/tcp_connection_handshake_table_top.sv
// ----------------------------------------------------------------------------
// TCP connection handshake table - top level
// Tracks TCP three-way handshakes in a table keyed by the four-tuple.
// ----------------------------------------------------------------------------
// Usage
//   Segment channel: drive req_data and raise start; the transfer happens at
//   the clock edge where start is high and busy is low. Two headers can be
//   queued ahead of the table engine, so start is normally taken at once.
//   Result channel: rsp_valid is high for exactly one cycle with rsp_data;
//   every accepted header gives one result, in order. The receiver cannot
//   stall; results must be taken in the cycle they appear.
//   Register port: APB-style, pready tied high. 0x0 initial send sequence,
//   0x4 initial send window (17 bits). Write only while the block is idle.
// Timing
//   The engine scans one stored entry per cycle through the table memory's
//   single read port. A miss reads every entry in use before the result;
//   a hit stops the scan at the matching entry.
// Reset
//   Synchronous, active high. Empties the queue, sets the used count to
//   zero (an empty table) and loads the register reset values. No clearing
//   pass: only entries below the used count are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_connection_handshake_table_top #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   // segment header channel
   input  logic                        start,
   output logic                        busy,
   input  tcht_pkg::req_type           req_data,
   // result channel
   output logic                        rsp_valid,
   output tcht_pkg::rsp_type           rsp_data,
   // register port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tcht_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import tcht_pkg::*;

   cfg_type        cfg;
   queue_head_type head;
   logic           pop;

   tcht_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Front: takes header transfers into the queue
   tcht_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .pop      (pop),
      .head     (head)
   );

   // Back: lookup, allocation, phase update and result
   tcht_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hw/rtl/tcht_csr.sv
// ----------------------------------------------------------------------------
// TCP connection handshake table - register block
// APB-style access to the initial send sequence and window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcht_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tcht_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output tcht_pkg::cfg_type           cfg
);
   import tcht_pkg::*;

   logic [31:0]      iss_ff,  iss_in;
   logic [WIN_W-1:0] win_ff,  win_in;
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   always_comb begin
      iss_in = iss_ff;
      win_in = win_ff;
      if (wr_en) begin
         case (paddr[2])
            CSR_SEL_ISS: iss_in = pwdata;
            CSR_SEL_WIN: win_in = pwdata[WIN_W-1:0];
            default:     iss_in = iss_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff <= ISS_RESET;
         win_ff <= WINDOW_RESET;
      end else begin
         iss_ff <= iss_in;
         win_ff <= win_in;
      end
   end

   assign prdata     = (paddr[2] == CSR_SEL_WIN) ? {{(32-WIN_W){1'b0}}, win_ff} : iss_ff;
   assign cfg.iss    = iss_ff;
   assign cfg.window = win_ff;

endmodule

FILE: hw/rtl/tcht_front.sv
// ----------------------------------------------------------------------------
// TCP connection handshake table - front end
// Takes segment headers and holds them in a two-deep queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcht_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  tcht_pkg::req_type        req_data,
   input  logic                     pop,
   output tcht_pkg::queue_head_type head
);
   import tcht_pkg::*;

   localparam int QDEPTH = 2;
   localparam int PTR_W  = $clog2(QDEPTH);
   localparam int CNT_W  = $clog2(QDEPTH + 1);

   req_type          q_item_ff [QDEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             push;
   logic             do_pop;

   assign busy   = (count_ff == CNT_W'(QDEPTH));
   assign push   = start & ~busy;
   assign do_pop = pop & head.valid;

   assign head.valid = (count_ff != '0);
   assign head.item  = q_item_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_item_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

FILE: hw/rtl/tcht_back.sv
// ----------------------------------------------------------------------------
// TCP connection handshake table - back end
// Scans the connection memory, creates or updates an entry where needed and issues the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tcp_connection_handshake_table_top_macros.svh"

module tcht_back #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tcht_pkg::queue_head_type head,
   output logic                     pop,
   input  tcht_pkg::cfg_type        cfg,
   output logic                     rsp_valid,
   output tcht_pkg::rsp_type        rsp_data
);
   import tcht_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   // Connection store; entries are allocated in order and never freed,
   // so the used count marks exactly the written entries.
   logic [TUPLE_W-1:0] tuple_mem [TABLE_ENTRIES];
   phase_type          phase_mem [TABLE_ENTRIES];
   logic [31:0]        ack_mem   [TABLE_ENTRIES];
   logic [31:0]        seq_mem   [TABLE_ENTRIES];
   logic [WIN_W-1:0]   win_mem   [TABLE_ENTRIES];

   logic [TUPLE_W-1:0] rd_tuple_ff;
   phase_type          rd_phase_ff;
   logic [31:0]        rd_ack_ff;
   logic [31:0]        rd_seq_ff;
   logic [WIN_W-1:0]   rd_win_ff;

   be_state_type       state_ff,  state_in;
   req_type            cur_ff,    cur_in;
   logic [CNT_W-1:0]   addr_ff,   addr_in;
   logic [CNT_W-1:0]   used_ff,   used_in;
   logic               pend_ff,   pend_in;
   logic [IDX_W-1:0]   pidx_ff,   pidx_in;
   logic               hit_ff,    hit_in;
   logic [IDX_W-1:0]   hidx_ff,   hidx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff,  rsp_data_in;

   logic               match_now;
   logic               rd_en;
   logic               we_new;
   logic               we_phase;
   logic               we_ack;
   logic [IDX_W-1:0]   wr_idx;
   phase_type          wr_phase;
   logic [31:0]        wr_ack;
   rsp_type            res;

   assign match_now = pend_ff && (rd_tuple_ff == tuple_of(cur_ff));

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      addr_in      = addr_ff;
      used_in      = used_ff;
      pend_in      = 1'b0;
      pidx_in      = pidx_ff;
      hit_in       = hit_ff;
      hidx_in      = hidx_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;
      we_new       = 1'b0;
      we_phase     = 1'b0;
      we_ack       = 1'b0;
      wr_idx       = hidx_ff;
      wr_phase     = PHASE_SYN_RCVD;
      wr_ack       = cur_ff.peer_sequence + 32'd1;
      res          = '0;

      case (state_ff)
         BE_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               cur_in   = head.item;
               addr_in  = '0;
               hit_in   = 1'b0;
               state_in = BE_SCAN;
            end
         end

         BE_SCAN: begin
            if (match_now) begin
               hit_in   = 1'b1;
               hidx_in  = pidx_ff;
               state_in = BE_WRITE;
            end else if (addr_ff < used_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               pidx_in = addr_ff[IDX_W-1:0];
               addr_in = addr_ff + 1'b1;
            end else begin
               state_in = BE_WRITE;
            end
         end

         BE_WRITE: begin
            if (hit_ff) begin
               res.hit               = 1'b1;
               res.slot              = SLOT_W'(hidx_ff);
               res.send_sequence_out = rd_seq_ff;
               res.send_window_out   = rd_win_ff;
               if (cur_ff.mode == MODE_SYN) begin
                  we_phase         = 1'b1;
                  we_ack           = 1'b1;
                  res.phase_after  = PHASE_SYN_RCVD;
                  res.ack_expected = wr_ack;
               end else begin
                  res.ack_expected = rd_ack_ff;
                  res.phase_after  = rd_phase_ff;
                  if (rd_phase_ff == PHASE_SYN_RCVD) begin
                     we_phase        = 1'b1;
                     wr_phase        = PHASE_ESTABLISHED;
                     res.phase_after = PHASE_ESTABLISHED;
                  end
               end
            end else if (cur_ff.mode == MODE_SYN) begin
               if (used_ff < CNT_W'(TABLE_ENTRIES)) begin
                  wr_idx                = used_ff[IDX_W-1:0];
                  we_new                = 1'b1;
                  we_phase              = 1'b1;
                  we_ack                = 1'b1;
                  used_in               = used_ff + 1'b1;
                  res.created           = 1'b1;
                  res.slot              = SLOT_W'(used_ff[IDX_W-1:0]);
                  res.phase_after       = PHASE_SYN_RCVD;
                  res.ack_expected      = wr_ack;
                  res.send_sequence_out = cfg.iss;
                  res.send_window_out   = cfg.window;
               end else begin
                  res.table_full = 1'b1;
               end
            end
            rsp_valid_in = 1'b1;
            rsp_data_in  = res;
            state_in     = BE_IDLE;
         end

         default: state_in = BE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BE_IDLE;
         used_ff      <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      addr_ff     <= addr_in;
      pidx_ff     <= pidx_in;
      hidx_ff     <= hidx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we_new) begin
         tuple_mem[wr_idx] <= tuple_of(cur_ff);
         seq_mem[wr_idx]   <= cfg.iss;
         win_mem[wr_idx]   <= cfg.window;
      end
      if (we_phase) begin
         phase_mem[wr_idx] <= wr_phase;
      end
      if (we_ack) begin
         ack_mem[wr_idx] <= wr_ack;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_tuple_ff <= tuple_mem[addr_ff[IDX_W-1:0]];
         rd_phase_ff <= phase_mem[addr_ff[IDX_W-1:0]];
         rd_ack_ff   <= ack_mem[addr_ff[IDX_W-1:0]];
         rd_seq_ff   <= seq_mem[addr_ff[IDX_W-1:0]];
         rd_win_ff   <= win_mem[addr_ff[IDX_W-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TCHT_ASSERT_IMP(a_used_bound, clock, reset, 1'b1, used_ff <= CNT_W'(TABLE_ENTRIES))
   `TCHT_ASSERT_IMP(a_read_written, clock, reset, rd_en, addr_ff < used_ff)
   `TCHT_ASSERT_NXT(a_single_strobe, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   `TCHT_ASSERT_IMP(a_result_kind, clock, reset, rsp_valid_ff,
                    !(rsp_data_ff.hit && rsp_data_ff.created) &&
                    !(rsp_data_ff.table_full && (rsp_data_ff.hit || rsp_data_ff.created)))
   `TCHT_ASSERT_NXT(a_create_counts, clock, reset, state_ff == BE_WRITE && we_new,
                    used_ff == $past(used_ff) + 1'b1)

endmodule

FILE: sim/tcht_checker.sv
// ----------------------------------------------------------------------------
// TCP connection handshake table - result checker
// Watches the segment, result and register ports, keeps its own copy of the
// connection table and compares every result transfer with its prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcht_checker #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  tcht_pkg::req_type           req_data,
   input  logic                        rsp_valid,
   input  tcht_pkg::rsp_type           rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic                        pready,
   input  logic [tcht_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output int                          fail_count,
   output int                          results_pending
);
   import tcht_pkg::*;

   localparam int MAX_REPORTS = 10;

   logic             conn_valid   [TABLE_ENTRIES];
   logic [95:0]      conn_key     [TABLE_ENTRIES];
   phase_type        conn_phase   [TABLE_ENTRIES];
   logic [31:0]      conn_ack     [TABLE_ENTRIES];
   logic [31:0]      conn_snd_seq [TABLE_ENTRIES];
   logic [WIN_W-1:0] conn_window  [TABLE_ENTRIES];

   logic [31:0]      cfg_iss;
   logic [WIN_W-1:0] cfg_window;

   rsp_type          expected_results[$];
   int               n_fail;

   // Updates the connection table for one segment and returns its result.
   function automatic rsp_type track_segment(input req_type seg);
      int          i;
      int          idx;
      logic [95:0] key;
      rsp_type     r;
      key = {seg.our_address, seg.peer_address, seg.our_port, seg.peer_port};
      r   = '0;
      idx = -1;
      for (i = 0; i < TABLE_ENTRIES; i++)
         if (idx < 0 && conn_valid[i] && conn_key[i] == key) idx = i;
      r.hit = (idx >= 0);
      if (seg.mode == MODE_SYN) begin
         if (idx < 0) begin
            for (i = 0; i < TABLE_ENTRIES; i++)
               if (idx < 0 && !conn_valid[i]) idx = i;
            if (idx < 0) begin
               r.table_full = 1'b1;
            end else begin
               r.created         = 1'b1;
               conn_valid[idx]   = 1'b1;
               conn_key[idx]     = key;
               conn_snd_seq[idx] = cfg_iss;
               conn_window[idx]  = cfg_window;
            end
         end
         if (idx >= 0) begin
            conn_phase[idx] = PHASE_SYN_RCVD;
            conn_ack[idx]   = seg.peer_sequence + 32'd1;
         end
      end else if (idx >= 0 && conn_phase[idx] == PHASE_SYN_RCVD) begin
         conn_phase[idx] = PHASE_ESTABLISHED;
      end
      if (idx >= 0) begin
         r.slot              = idx[SLOT_W-1:0];
         r.phase_after       = conn_phase[idx];
         r.ack_expected      = conn_ack[idx];
         r.send_sequence_out = conn_snd_seq[idx];
         r.send_window_out   = conn_window[idx];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int      i;
      if (reset) begin
         for (i = 0; i < TABLE_ENTRIES; i++) conn_valid[i] = 1'b0;
         cfg_iss    = ISS_RESET;
         cfg_window = WINDOW_RESET;
         expected_results.delete();
         n_fail = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == CSR_SEL_WIN) cfg_window = pwdata[WIN_W-1:0];
            else                         cfg_iss    = pwdata;
         end
         // results are for earlier segments, so retire before predicting
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               if (n_fail < MAX_REPORTS)
                  $display("%0t checker: result with nothing expected, got %h",
                           $realtime, rsp_data);
               n_fail++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.hit !== want.hit || rsp_data.created !== want.created ||
                   rsp_data.table_full !== want.table_full ||
                   rsp_data.slot !== want.slot ||
                   rsp_data.phase_after !== want.phase_after ||
                   rsp_data.ack_expected !== want.ack_expected ||
                   rsp_data.send_sequence_out !== want.send_sequence_out ||
                   rsp_data.send_window_out !== want.send_window_out) begin
                  if (n_fail < MAX_REPORTS) begin
                     $display("%0t checker: mismatch (hit created full slot phase ack seq win)",
                              $realtime);
                     $display("   expected %b %b %b %0d %0d %h %h %h", want.hit,
                              want.created, want.table_full, want.slot, want.phase_after,
                              want.ack_expected, want.send_sequence_out,
                              want.send_window_out);
                     $display("   actual   %b %b %b %0d %0d %h %h %h", rsp_data.hit,
                              rsp_data.created, rsp_data.table_full, rsp_data.slot,
                              rsp_data.phase_after, rsp_data.ack_expected,
                              rsp_data.send_sequence_out, rsp_data.send_window_out);
                  end
                  n_fail++;
               end
            end
         end
         if (start && !busy) expected_results.push_back(track_segment(req_data));
      end
      fail_count      <= n_fail;
      results_pending <= expected_results.size();
   end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// TCP connection handshake table - testbench top
// Drives segment headers and register writes into the table, and leaves the
// checking to tcht_checker. A short directed run covers the handshake corner
// cases, then six random phases with different register settings and sender
// idling fill the table up and run it into the table-full case.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import tcht_pkg::*;

   localparam int TABLE_ENTRIES = 16;
   localparam int QUIET_LIMIT   = 2000;   // cycles with no transfer at all
   localparam int PHASE_ITEMS   = 150;
   localparam int N_PHASES      = 6;
   localparam int DRAIN_CYCLES  = 40;     // well above a full-table scan

   localparam logic [CSR_AW-1:0] ADDR_ISS = {CSR_SEL_ISS, 2'b00};
   localparam logic [CSR_AW-1:0] ADDR_WIN = {CSR_SEL_WIN, 2'b00};

   logic              clock;
   logic              reset    = 1'b1;
   logic              start    = 1'b0;
   req_type           req_data = '0;
   logic              psel     = 1'b0;
   logic              penable  = 1'b0;
   logic              pwrite   = 1'b0;
   logic [CSR_AW-1:0] paddr    = '0;
   logic [31:0]       pwdata   = '0;

   logic              busy;
   logic              rsp_valid;
   rsp_type           rsp_data;
   logic [31:0]       prdata;
   logic              pready;

   int                fail_count;
   int                results_pending;
   int                quiet_cycles = 0;

   // tuples known to sit in the table, reused to build real handshakes
   req_type           opened[$];
   int                idle_pct   = 0;
   int                new_budget = 0;

   tcp_connection_handshake_table_top #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   tcht_checker #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .fail_count      (fail_count),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: any transfer on any port restarts the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable && pready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("tb: errors");
      $finish;
   end

   // Mostly random, with all-zero and all-one values often enough to matter.
   function automatic logic [31:0] skewed_word();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type fresh_tuple();
      req_type t;
      t              = '0;
      t.our_address  = skewed_word();
      t.peer_address = skewed_word();
      t.our_port     = 16'(skewed_word());
      t.peer_port    = 16'(skewed_word());
      return t;
   endfunction

   // Same four-tuple with one bit flipped: must never match the original.
   function automatic req_type near_miss(input req_type t);
      logic [95:0] key;
      req_type     n;
      int          b;
      n   = t;
      key = {t.our_address, t.peer_address, t.our_port, t.peer_port};
      b   = $urandom_range(95);
      key[b] = ~key[b];
      {n.our_address, n.peer_address, n.our_port, n.peer_port} = key;
      return n;
   endfunction

   function automatic void note_open(input req_type t);
      if (opened.size() < TABLE_ENTRIES) opened.push_back(t);
   endfunction

   // One segment transfer. start is left high so a following segment can go
   // straight out; it only drops for an idle gap or a pause.
   task automatic send_segment(input logic mode, input req_type tuple,
                               input logic [31:0] seq);
      req_type seg;
      seg               = tuple;
      seg.mode          = mode;
      seg.peer_sequence = seq;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= seg;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_all_results();
      start <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
   endtask

   // Both registers, once the table has gone quiet. Junk above bit 16 of the
   // window write checks that only 17 bits are kept.
   task automatic configure(input logic [31:0] iss, input logic [WIN_W-1:0] win);
      wait_all_results();
      psel   <= 1'b1;
      pwrite <= 1'b1;
      paddr  <= ADDR_ISS;
      pwdata <= iss;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      penable <= 1'b0;
      paddr   <= ADDR_WIN;
      pwdata  <= {15'($urandom), win};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Mostly handshakes on known connections; the rest are misses, near misses
   // and new SYNs, the latter rationed so the table fills across the phases.
   task automatic random_segment();
      req_type t;
      int      r;
      logic    mode;
      r    = $urandom_range(99);
      mode = 1'($urandom_range(1));
      if (opened.size() != 0 && r < 70) begin
         t = opened[$urandom_range(opened.size() - 1)];
      end else begin
         if (opened.size() != 0 && r < 85) t = near_miss(opened[$urandom_range(opened.size() - 1)]);
         else                              t = fresh_tuple();
         if (mode == MODE_SYN) begin
            if (new_budget > 0) begin
               new_budget--;
               note_open(t);
            end else begin
               mode = MODE_ACK;
            end
         end
      end
      send_segment(mode, t, skewed_word());
   endtask

   initial begin
      req_type          zero_t;
      req_type          ones_t;
      req_type          t;
      logic [31:0]      phase_iss  [N_PHASES];
      logic [WIN_W-1:0] phase_win  [N_PHASES];
      int               phase_idle [N_PHASES];
      int               p;

      // register extremes first, then random settings
      phase_iss[0] = '0;       phase_win[0] = '0;            phase_idle[0] = 0;
      phase_iss[1] = '1;       phase_win[1] = '1;            phase_idle[1] = 79;
      phase_iss[2] = $urandom; phase_win[2] = 17'd65536;     phase_idle[2] = 0;
      phase_iss[3] = $urandom; phase_win[3] = 17'($urandom); phase_idle[3] = 20;
      phase_iss[4] = $urandom; phase_win[4] = 17'd1;         phase_idle[4] = 79;
      phase_iss[5] = $urandom; phase_win[5] = 17'd65535;     phase_idle[5] = 0;

      zero_t = '0;
      ones_t = '1;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset register values, full handshake, ACK on an
      // established entry, SYN again on it with sequence wrap, misses.
      send_segment(MODE_SYN, zero_t, 32'h0000_0000);
      note_open(zero_t);
      send_segment(MODE_ACK, zero_t, 32'h0000_0000);
      send_segment(MODE_ACK, zero_t, 32'hFFFF_FFFF);
      send_segment(MODE_SYN, zero_t, 32'hFFFF_FFFF);
      send_segment(MODE_ACK, fresh_tuple(), 32'h5555_5555);
      send_segment(MODE_SYN, ones_t, 32'hFFFF_FFFF);
      note_open(ones_t);
      send_segment(MODE_ACK, ones_t, 32'hAAAA_AAAA);
      t = ones_t;
      t.peer_port = 16'hFFFE;
      send_segment(MODE_ACK, t, 32'h0000_0001);
      t = zero_t;
      t.peer_port = 16'h0001;
      send_segment(MODE_SYN, t, 32'h8000_0000);
      note_open(t);
      send_segment(MODE_ACK, t, 32'h7FFF_FFFF);

      // new entries under zero and all-one register values
      configure('0, '0);
      t = fresh_tuple();
      send_segment(MODE_SYN, t, $urandom);
      note_open(t);
      send_segment(MODE_ACK, t, $urandom);
      configure('1, '1);
      t = fresh_tuple();
      send_segment(MODE_SYN, t, $urandom);
      note_open(t);
      send_segment(MODE_SYN, t, 32'hFFFF_FFFF);
      send_segment(MODE_ACK, t, $urandom);

      // Random phases. Each reconfiguration waits for every result, which
      // also gives the full-stop pause on the sender side.
      for (p = 0; p < N_PHASES; p++) begin
         configure(phase_iss[p], phase_win[p]);
         idle_pct   = phase_idle[p];
         new_budget = (p == N_PHASES - 1) ? PHASE_ITEMS : 2;
         repeat (PHASE_ITEMS) random_segment();
      end

      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

FILE: tcp_connection_handshake_table_top.f
+incdir+hw/rtl
hw/rtl/tcht_pkg.sv
hw/rtl/tcht_csr.sv
hw/rtl/tcht_front.sv
hw/rtl/tcht_back.sv
hw/rtl/tcp_connection_handshake_table_top.sv
sim/tcht_checker.sv
sim/tb.sv
